### sv/pts_pkg.sv
// package for the periodic task scheduler
// holds the word types, function and result codes, and the cell command type
// no dependencies
package pts_pkg;

	// default table capacity and the fixed width of a task index
	localparam int unsigned MAX_TASKS_DEF = 8;
	localparam int unsigned TASK_ID_W     = 3;
	localparam int unsigned SLOT_LIMIT    = 8;
	localparam int unsigned PERIOD_W      = 16;

	// input function codes
	localparam logic [1:0] F_TICK = 2'd0;
	localparam logic [1:0] F_RUN  = 2'd1;
	localparam logic [1:0] F_ADD  = 2'd2;
	localparam logic [1:0] F_SET  = 2'd3;

	// result kinds
	typedef enum logic [2:0] {
		K_ADDED  = 3'd0,
		K_FULL   = 3'd1,
		K_ENABLE = 3'd2,
		K_TICK   = 3'd3,
		K_DUE    = 3'd4,
		K_NONE   = 3'd5
	} kind_t;

	// input word
	typedef struct packed {
		logic [1:0]           func;
		logic [TASK_ID_W-1:0] task_id;
		logic [PERIOD_W-1:0]  period;
		logic                 enable;
	} in_t;

	// result word
	typedef struct packed {
		logic [2:0]           kind;
		logic [TASK_ID_W-1:0] task_id_res;
		logic                 last;
	} out_t;

	// operation broadcast to every cell
	typedef enum logic [2:0] {
		C_NOP,
		C_TICK,
		C_ADD,
		C_SET,
		C_STEP
	} cell_op_t;

	// command bundle from the sequencer to the cells
	typedef struct packed {
		cell_op_t             op;
		logic                 shift;
		logic [TASK_ID_W-1:0] tgt;
		logic [PERIOD_W-1:0]  period;
		logic                 enable;
	} cell_cmd_t;

endpackage

### sv/periodic_task_scheduler_unit.sv
// top level of the periodic task scheduler: sequencer, output register and the cell chain
// tick, add and set enable each give a single result word, registered on acceptance and offered in the cycle after
// a run walks the chain one cell a cycle while the output register is free, over MAX_TASKS cells (capped at 8),
// then closes in a flush state that gives the last word; one item at a time
// reset: all tasks cleared and disabled, no word pending; period and counter storage is
// left unset until a task is added
module periodic_task_scheduler_unit #(
	parameter int unsigned MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pts_pkg::in_t  in_word,
	output logic          out_valid,
	input  logic          out_ready,
	output pts_pkg::out_t out_word
);
	import pts_pkg::*;

	localparam int unsigned SLOT_CAP = (MAX_TASKS < SLOT_LIMIT) ? MAX_TASKS : SLOT_LIMIT;
	localparam int unsigned CNT_W    = $clog2(SLOT_CAP + 1);
	localparam int unsigned SCAN_W   = (SLOT_CAP > 1) ? $clog2(SLOT_CAP) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [SCAN_W-1:0]    scan_q;
	logic                 pend_vld_q;
	logic [TASK_ID_W-1:0] pend_id_q;
	logic                 out_vld_q;
	out_t                 res_q;

	logic                 out_free;
	logic                 out_load;
	logic                 acc;
	logic                 full;
	logic                 start;
	logic                 step;
	logic                 any_hit;
	cell_cmd_t            cmd;
	logic [SLOT_CAP:0]    tok;
	logic [SLOT_CAP-1:0]  hits;

	assign out_free  = !out_vld_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign acc       = in_valid && in_ready;
	assign full      = (count_q == CNT_W'(SLOT_CAP));
	assign start     = acc && (in_word.func == F_RUN);
	assign step      = (state_q == S_SCAN) && out_free;
	assign any_hit   = |hits;
	assign out_valid = out_vld_q;
	assign out_word  = res_q;

	// a new result word enters the output register
	assign out_load  = (acc && (in_word.func != F_RUN)) ||
		(step && any_hit && pend_vld_q) ||
		((state_q == S_FLUSH) && out_free);

	// command broadcast to the chain
	always_comb begin
		cmd        = '0;
		cmd.op     = C_NOP;
		cmd.shift  = start || step;
		cmd.period = in_word.period;
		cmd.enable = in_word.enable;
		cmd.tgt    = in_word.task_id;
		if (acc) begin
			case (in_word.func)
				F_TICK: cmd.op = C_TICK;
				F_ADD: begin
					if (!full) begin
						cmd.op  = C_ADD;
						cmd.tgt = TASK_ID_W'(count_q);
					end
				end
				F_SET: cmd.op = C_SET;
				default: cmd.op = C_NOP;
			endcase
		end else if (step) begin
			cmd.op = C_STEP;
		end
	end

	// chain of task cells, token enters at cell zero
	assign tok[0] = start;
	for (genvar g = 0; g < SLOT_CAP; g++) begin : g_cell
		pts_cell #(
			.IDX(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.token_in (tok[g]),
			.token_out(tok[g+1]),
			.hit      (hits[g])
		);
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			scan_q     <= '0;
			pend_vld_q <= 1'b0;
			pend_id_q  <= '0;
			out_vld_q  <= 1'b0;
			res_q      <= '0;
		end else begin
			// result valid flag
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (in_word.func)
							F_TICK: begin
								res_q <= '{kind: K_TICK, task_id_res: '0, last: 1'b1};
							end
							F_ADD: begin
								if (full) begin
									res_q <= '{kind: K_FULL, task_id_res: '0, last: 1'b1};
								end else begin
									res_q   <= '{kind: K_ADDED,
										task_id_res: TASK_ID_W'(count_q), last: 1'b1};
									count_q <= count_q + CNT_W'(1);
								end
							end
							F_SET: begin
								res_q <= '{kind: K_ENABLE, task_id_res: '0, last: 1'b1};
							end
							default: begin
								state_q    <= S_SCAN;
								scan_q     <= '0;
								pend_vld_q <= 1'b0;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (out_free) begin
						// a new due task pushes the held one out as not last
						if (any_hit) begin
							pend_vld_q <= 1'b1;
							pend_id_q  <= TASK_ID_W'(scan_q);
							if (pend_vld_q) begin
								res_q <= '{kind: K_DUE, task_id_res: pend_id_q,
									last: 1'b0};
							end
						end
						if (scan_q == SCAN_W'(SLOT_CAP - 1)) begin
							state_q <= S_FLUSH;
						end else begin
							scan_q <= scan_q + SCAN_W'(1);
						end
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						if (pend_vld_q) begin
							res_q <= '{kind: K_DUE, task_id_res: pend_id_q, last: 1'b1};
						end else begin
							res_q <= '{kind: K_NONE, task_id_res: '0, last: 1'b1};
						end
						pend_vld_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	a_pend_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> (state_q != S_IDLE))
		else $error("due task held outside a run");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok[SLOT_CAP:1]))
		else $error("more than one scan token in the chain");

	a_token_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(|tok[SLOT_CAP:1]) == (state_q == S_SCAN))
		else $error("scan token does not match sequencer state");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOT_CAP))
		else $error("task count beyond capacity");

endmodule

### sv/pts_cell.sv
// one task slot of the scheduler chain: period, down counter, enable and in-use flag
// passes the scan token on to its neighbour
// depends on pts_pkg
module pts_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pts_pkg::cell_cmd_t cmd,
	input  logic              token_in,
	output logic              token_out,
	output logic              hit
);
	import pts_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] count_q;
	logic                en_q;
	logic                use_q;
	logic                tok_q;
	logic                sel;
	logic                zero;

	assign sel       = (cmd.tgt == TASK_ID_W'(IDX));
	assign zero      = (count_q == '0);
	assign hit       = tok_q && use_q && en_q && zero;
	assign token_out = tok_q;

	// control flags and the scan token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			use_q <= 1'b0;
			tok_q <= 1'b0;
		end else begin
			if (cmd.shift) begin
				tok_q <= token_in;
			end
			case (cmd.op)
				C_ADD: begin
					if (sel) begin
						use_q <= 1'b1;
						en_q  <= 1'b1;
					end
				end
				C_SET: begin
					if (sel && use_q) begin
						en_q <= cmd.enable;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// period and counter storage
	always_ff @(posedge clk) begin
		case (cmd.op)
			C_ADD: begin
				if (sel) begin
					period_q <= cmd.period;
					count_q  <= cmd.period;
				end
			end
			C_SET: begin
				if (sel && use_q && cmd.enable) begin
					count_q <= period_q;
				end
			end
			C_TICK: begin
				if (use_q && en_q && !zero) begin
					count_q <= count_q - PERIOD_W'(1);
				end
			end
			C_STEP: begin
				if (hit) begin
					count_q <= period_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### dv/pts_checker.sv
`timescale 1ns / 100ps
// checker for the periodic task scheduler: follows input and result words on both channels,
// predicts every result from its own copy of the task table and compares field by field
// depends on pts_pkg
module pts_checker #(
	parameter int unsigned MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  pts_pkg::in_t  in_word,
	input  logic          out_valid,
	input  logic          out_ready,
	input  pts_pkg::out_t out_word,
	output int            fails,
	output int            pending
);
	import pts_pkg::*;

	// usable table size: never more than a 3-bit index can name
	localparam int unsigned CAP = (MAX_TASKS < SLOT_LIMIT) ? MAX_TASKS : SLOT_LIMIT;

	typedef struct packed {
		kind_t                kind;
		logic [TASK_ID_W-1:0] task_id;
		logic                 last;
	} outcome_t;

	// predicted task table
	logic [PERIOD_W-1:0]   period_of [SLOT_LIMIT];
	logic [PERIOD_W-1:0]   countdown [SLOT_LIMIT];
	logic [SLOT_LIMIT-1:0] armed;
	int unsigned           tasks_held;

	// result words still awaited, oldest first
	outcome_t outcomes_q[$];
	outcome_t want;

	function automatic void note_fault(string msg);
		fails++;
		if (fails <= 10) begin
			$display("%t %s", $time, msg);
		end
	endfunction

	function automatic void add_outcome(kind_t k, logic [TASK_ID_W-1:0] id);
		outcome_t o;
		o.kind    = k;
		o.task_id = id;
		o.last    = 1'b0;
		outcomes_q.push_back(o);
	endfunction

	// apply one input word to the predicted table and queue the words it yields
	function automatic void schedule_word(in_t w);
		int unsigned i;
		int unsigned due_seen;
		due_seen = 0;
		case (w.func)
			F_TICK: begin
				// count down enabled tasks that are not yet at zero
				for (i = 0; i < tasks_held; i++) begin
					if (armed[i] && countdown[i] != '0) begin
						countdown[i] = countdown[i] - 1'b1;
					end
				end
				add_outcome(K_TICK, '0);
			end
			F_RUN: begin
				// report due tasks in index order and reload them
				for (i = 0; i < tasks_held; i++) begin
					if (armed[i] && countdown[i] == '0) begin
						countdown[i] = period_of[i];
						add_outcome(K_DUE, i[TASK_ID_W-1:0]);
						due_seen++;
					end
				end
				if (due_seen == 0) begin
					add_outcome(K_NONE, '0);
				end
			end
			F_ADD: begin
				if (tasks_held >= CAP) begin
					add_outcome(K_FULL, '0);
				end else begin
					period_of[tasks_held] = w.period;
					countdown[tasks_held] = w.period;
					armed[tasks_held]     = 1'b1;
					add_outcome(K_ADDED, tasks_held[TASK_ID_W-1:0]);
					tasks_held++;
				end
			end
			default: begin
				// set enable: indices not yet in use leave the table alone
				if (w.task_id < tasks_held) begin
					armed[w.task_id] = w.enable;
					if (w.enable) begin
						countdown[w.task_id] = period_of[w.task_id];
					end
				end
				add_outcome(K_ENABLE, '0);
			end
		endcase
		outcomes_q[outcomes_q.size() - 1].last = 1'b1;
	endfunction

	// compare accepted result words, then predict from accepted input words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed      = '0;
			tasks_held = 0;
			fails      = 0;
			outcomes_q.delete();
			pending    = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (outcomes_q.size() == 0) begin
					note_fault($sformatf("result word with nothing awaited: kind %0d id %0d last %0b",
						out_word.kind, out_word.task_id_res, out_word.last));
				end else begin
					want = outcomes_q.pop_front();
					if (out_word.kind != want.kind || out_word.task_id_res != want.task_id ||
						out_word.last != want.last) begin
						note_fault($sformatf(
							"result mismatch: expected kind %s id %0d last %0b, got kind %0d id %0d last %0b",
							want.kind.name(), want.task_id, want.last,
							out_word.kind, out_word.task_id_res, out_word.last));
					end
				end
			end
			if (in_valid && in_ready) begin
				schedule_word(in_word);
			end
			pending = outcomes_q.size();
		end
	end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// testbench top for the periodic task scheduler: clock, reset, input traffic with idle
// phases, result-side stalls and a long hold-off, and the final verdict
// depends on pts_pkg, periodic_task_scheduler_unit and pts_checker
module tb;
	import pts_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_word;
	int   fails;
	int   pending;
	int   send_idle = 0;
	int   recv_idle = 0;
	int   hold_asks = 0;

	always #2 clk = ~clk;

	periodic_task_scheduler_unit #(
		.MAX_TASKS(MAX_TASKS_DEF)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	pts_checker #(
		.MAX_TASKS(MAX_TASKS_DEF)
	) chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word),
		.fails    (fails),
		.pending  (pending)
	);

	// offer one word, after a random gap, and hold it until accepted
	task automatic send_word(in_t w);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic issue(logic [1:0] f, logic [TASK_ID_W-1:0] id, logic [PERIOD_W-1:0] p,
		logic e);
		in_t w;
		w.func    = f;
		w.task_id = id;
		w.period  = p;
		w.enable  = e;
		send_word(w);
	endtask

	// mostly ticks and runs, with enables and adds mixed in
	task automatic random_items(int count);
		in_t w;
		int unsigned pick;
		int k;
		for (k = 0; k < count; k++) begin
			pick      = $urandom_range(99);
			w.task_id = TASK_ID_W'($urandom_range(7));
			w.enable  = 1'($urandom_range(1));
			w.period  = ($urandom_range(3) == 0) ? PERIOD_W'($urandom) :
				PERIOD_W'($urandom_range(5));
			if (pick < 40) begin
				w.func = F_TICK;
			end else if (pick < 70) begin
				w.func = F_RUN;
			end else if (pick < 88) begin
				w.func = F_SET;
			end else begin
				w.func = F_ADD;
			end
			send_word(w);
		end
	endtask

	// result side: random stalls, or a long hold-off when asked for
	initial begin
		int hold_seen;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// stimulus and verdict
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// empty table: run with nothing due, tick, enables on unused indices
		issue(F_RUN, 3'd0, 16'h0000, 1'b0);
		issue(F_TICK, 3'd0, 16'h0000, 1'b0);
		issue(F_SET, 3'd7, 16'h0000, 1'b1);
		issue(F_SET, 3'd0, 16'hffff, 1'b0);

		// zero period, largest period and period one
		issue(F_ADD, 3'd0, 16'h0000, 1'b0);
		issue(F_ADD, 3'd5, 16'hffff, 1'b1);
		issue(F_ADD, 3'd2, 16'h0001, 1'b0);
		issue(F_RUN, 3'd0, 16'h0000, 1'b0);
		issue(F_TICK, 3'd0, 16'h0000, 1'b0);
		issue(F_RUN, 3'd0, 16'h0000, 1'b0);

		// disable keeps the counter, enable reloads it
		issue(F_SET, 3'd0, 16'h0000, 1'b0);
		issue(F_RUN, 3'd0, 16'h0000, 1'b0);
		issue(F_SET, 3'd1, 16'h0000, 1'b0);
		issue(F_SET, 3'd1, 16'h0000, 1'b1);
		issue(F_SET, 3'd0, 16'h0000, 1'b1);
		issue(F_TICK, 3'd0, 16'h0000, 1'b0);
		issue(F_RUN, 3'd0, 16'h0000, 1'b0);

		// fill the table, then one add too many
		issue(F_ADD, 3'd0, 16'h0002, 1'b0);
		issue(F_ADD, 3'd0, 16'h0003, 1'b0);
		issue(F_ADD, 3'd0, 16'h5555, 1'b0);
		issue(F_ADD, 3'd0, 16'h0004, 1'b0);
		issue(F_ADD, 3'd0, 16'haaaa, 1'b0);
		issue(F_ADD, 3'd7, 16'h0007, 1'b1);
		issue(F_SET, 3'd7, 16'h0000, 1'b0);
		issue(F_RUN, 3'd0, 16'h0000, 1'b0);

		// no idling, with a long result hold-off to back up the input
		hold_asks++;
		random_items(45);

		send_idle = 75;
		recv_idle = 0;
		random_items(45);

		send_idle = 0;
		recv_idle = 75;
		random_items(45);

		send_idle = 29;
		recv_idle = 29;
		random_items(50);

		// drop the input, then wait until the checker awaits no more result words and let the output drain
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
sv/pts_pkg.sv
sv/pts_cell.sv
sv/periodic_task_scheduler_unit.sv
dv/pts_checker.sv
dv/tb.sv
